// ===== hdl/lrue_pkg.sv =====
package lrue_pkg;

   // Field and register widths fixed by the interface
   localparam int CFG_W     = 7;
   localparam int CSR_IDX_W = 1;
   localparam int IDX_W     = 6;
   localparam int USE_W     = 32;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_CACHE_CAPACITY = 1'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ACTIVE_ENTRIES = 1'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] CAPACITY_RESET = 7'd8;
   localparam logic [CFG_W-1:0] ACTIVE_RESET   = 7'd64;

   // Per-beat control from the sequencer to the victim scan unit
   typedef struct packed {
      logic start;         // clear accumulators
      logic beat_valid;    // a stamp arrives this cycle
      logic beat_cached;   // that entry is cached
   } scan_ctl_type;

endpackage

// ===== hdl/lrue_ram.sv =====
module lrue_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

// ===== hdl/lrue_scan.sv =====
module lrue_scan
   import lrue_pkg::*;
#(
   parameter int ENTRIES    = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  scan_ctl_type          ctl,
   input  logic [((($clog2(ENTRIES+1)) > CFG_W) ? $clog2(ENTRIES+1) : CFG_W)-1:0] beat_idx,
   input  logic [COUNT_BITS-1:0] beat_stamp,
   output logic [CFG_W-1:0]      count,
   output logic                  found,
   output logic [((($clog2(ENTRIES+1)) > CFG_W) ? $clog2(ENTRIES+1) : CFG_W)-1:0] victim
);

   localparam int LIM_W = (($clog2(ENTRIES+1)) > CFG_W) ? $clog2(ENTRIES+1) : CFG_W;

   logic [CFG_W-1:0]      count_ff, count_in;
   logic                  found_ff, found_in;
   logic [LIM_W-1:0]      victim_ff, victim_in;
   logic [COUNT_BITS-1:0] best_ff, best_in;
   logic                  older;

   // the one shared comparator: strict less keeps the lowest index on ties
   assign older = beat_stamp < best_ff;

   always_comb begin
      count_in  = count_ff;
      found_in  = found_ff;
      victim_in = victim_ff;
      best_in   = best_ff;
      if (ctl.start) begin
         count_in  = '0;
         found_in  = 1'b0;
         victim_in = '0;
         best_in   = '0;
      end else if (ctl.beat_valid && ctl.beat_cached) begin
         count_in = count_ff + 1'b1;
         if (!found_ff || older) begin
            found_in  = 1'b1;
            victim_in = beat_idx;
            best_in   = beat_stamp;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         found_ff <= found_in;
      end
      victim_ff <= victim_in;
      best_ff   <= best_in;
   end

   assign count  = count_ff;
   assign found  = found_ff;
   assign victim = victim_ff;

endmodule

// ===== hdl/lru_entry_cache_policy_core.sv =====
// LRU entry cache policy with time stamps.
// Input channel (req_*): one beat names a table entry. Result channel (rsp_*):
// one beat per input beat, in order: hit / inserted / evicted flags, victim
// index, the entry's saturating use count, and an out-of-range flag.
// CSR port: csr_write with csr_index selects cache_capacity (0) or
// active_entries (1); write only while the block is idle.
// Throughput: one item at a time. An out-of-range beat goes from accept to
// DONE; a hit or a zero-capacity miss passes READ and then DONE.
// Any other miss scans the stamps of all active entries, one per cycle through
// the shared comparator and the single read port of the entry RAM, then passes
// DECIDE and DONE. The result beat shows in the same cycle that the next
// accept becomes possible.
// req_stall is high from accept until the result is loaded into the output
// register.
// Reset: cached flags, time counter and CSRs reset at once; then a clearing
// pass writes zero to all ENTRIES words of the entry RAM with req_stall
// high.
// A stalled result beat holds in the output register; the next request is
// accepted meanwhile, and its result waits until the register frees.
module lru_entry_cache_policy_core
   import lrue_pkg::*;
#(
   parameter int ENTRIES    = 64,
   parameter int COUNT_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   // request channel
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [IDX_W-1:0]     req_entry_index,
   // result channel
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic                 rsp_was_hit,
   output logic                 rsp_inserted,
   output logic                 rsp_evicted,
   output logic [IDX_W-1:0]     rsp_victim_index,
   output logic [USE_W-1:0]     rsp_use_count,
   output logic                 rsp_out_of_range,
   // CSR write port
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   localparam int ADDR_W = $clog2(ENTRIES);
   localparam int LIM_W  = (($clog2(ENTRIES+1)) > CFG_W) ? $clog2(ENTRIES+1) : CFG_W;
   localparam int WORD_W = 2 * COUNT_BITS;   // {use total, last stamp}

   localparam logic [2:0] ST_CLEAR  = 3'd0;
   localparam logic [2:0] ST_IDLE   = 3'd1;
   localparam logic [2:0] ST_READ   = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_DONE   = 3'd5;

   logic [2:0]            state_ff, state_in;
   logic [CFG_W-1:0]      capacity_ff, capacity_in;
   logic [CFG_W-1:0]      active_ff, active_in;
   logic [COUNT_BITS-1:0] time_ff, time_in;
   logic [ENTRIES-1:0]    cached_ff, cached_in;
   logic [LIM_W-1:0]      ptr_ff, ptr_in;
   logic [LIM_W-1:0]      idx_ff, idx_in;

   // pending scan beat (RAM read in flight)
   logic                  pend_valid_ff, pend_valid_in;
   logic                  pend_cached_ff, pend_cached_in;
   logic [LIM_W-1:0]      pend_idx_ff, pend_idx_in;

   // result under construction
   logic                  res_hit_ff, res_hit_in;
   logic                  res_ins_ff, res_ins_in;
   logic                  res_ev_ff, res_ev_in;
   logic [IDX_W-1:0]      res_victim_ff, res_victim_in;
   logic [USE_W-1:0]      res_use_ff, res_use_in;
   logic                  res_oor_ff, res_oor_in;

   // output register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic                  rsp_ins_ff, rsp_ins_in;
   logic                  rsp_ev_ff, rsp_ev_in;
   logic [IDX_W-1:0]      rsp_victim_ff, rsp_victim_in;
   logic [USE_W-1:0]      rsp_use_ff, rsp_use_in;
   logic                  rsp_oor_ff, rsp_oor_in;

   logic [LIM_W-1:0]      limit;
   logic [LIM_W-1:0]      active_ext;
   logic [LIM_W-1:0]      req_idx_ext;
   logic                  req_accept;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [WORD_W-1:0]     ram_wr_data;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [WORD_W-1:0]     ram_rd_data;
   logic [COUNT_BITS-1:0] old_total;
   logic [COUNT_BITS-1:0] new_total;
   logic [ADDR_W-1:0]     idx_addr;
   logic [ADDR_W-1:0]     ptr_addr;

   scan_ctl_type          scan_ctl;
   logic [CFG_W-1:0]      scan_count;
   logic                  scan_found;
   logic [LIM_W-1:0]      scan_victim;
   logic [ADDR_W-1:0]     victim_addr;

   // active limit, clipped to the table size
   assign active_ext  = LIM_W'(active_ff);
   assign limit       = (active_ext < LIM_W'(ENTRIES)) ? active_ext : LIM_W'(ENTRIES);
   assign req_idx_ext = LIM_W'(req_entry_index);
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_accept  = req_valid && !req_stall;

   assign idx_addr    = idx_ff[ADDR_W-1:0];
   assign ptr_addr    = ptr_ff[ADDR_W-1:0];
   assign victim_addr = scan_victim[ADDR_W-1:0];

   assign old_total = ram_rd_data[WORD_W-1:COUNT_BITS];
   assign new_total = (old_total == {COUNT_BITS{1'b1}}) ? old_total : old_total + 1'b1;

   lrue_ram #(
      .WIDTH (WORD_W),
      .DEPTH (ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   lrue_scan #(
      .ENTRIES    (ENTRIES),
      .COUNT_BITS (COUNT_BITS)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .ctl        (scan_ctl),
      .beat_idx   (pend_idx_ff),
      .beat_stamp (ram_rd_data[COUNT_BITS-1:0]),
      .count      (scan_count),
      .found      (scan_found),
      .victim     (scan_victim)
   );

   // CSR writes
   always_comb begin
      capacity_in = capacity_ff;
      active_in   = active_ff;
      if (csr_write) begin
         case (csr_index)
            REG_CACHE_CAPACITY: capacity_in = csr_wdata;
            REG_ACTIVE_ENTRIES: active_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      time_in        = time_ff;
      cached_in      = cached_ff;
      ptr_in         = ptr_ff;
      idx_in         = idx_ff;
      pend_valid_in  = 1'b0;
      pend_cached_in = 1'b0;
      pend_idx_in    = ptr_ff;
      res_hit_in     = res_hit_ff;
      res_ins_in     = res_ins_ff;
      res_ev_in      = res_ev_ff;
      res_victim_in  = res_victim_ff;
      res_use_in     = res_use_ff;
      res_oor_in     = res_oor_ff;
      ram_wr_en      = 1'b0;
      ram_wr_addr    = idx_addr;
      ram_wr_data    = {new_total, time_ff};
      ram_rd_addr    = ptr_addr;
      scan_ctl       = '0;

      // output register frees on a taken beat
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_hit_in    = rsp_hit_ff;
      rsp_ins_in    = rsp_ins_ff;
      rsp_ev_in     = rsp_ev_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_use_in    = rsp_use_ff;
      rsp_oor_in    = rsp_oor_ff;

      case (state_ff)
         ST_CLEAR: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = ptr_addr;
            ram_wr_data = '0;
            ptr_in      = ptr_ff + 1'b1;
            if (ptr_ff == LIM_W'(ENTRIES - 1)) begin
               ptr_in   = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            ram_rd_addr = req_idx_ext[ADDR_W-1:0];
            if (req_accept) begin
               idx_in        = req_idx_ext;
               res_hit_in    = 1'b0;
               res_ins_in    = 1'b0;
               res_ev_in     = 1'b0;
               res_victim_in = '0;
               res_use_in    = '0;
               res_oor_in    = !(req_idx_ext < limit);
               state_in      = (req_idx_ext < limit) ? ST_READ : ST_DONE;
            end
         end
         ST_READ: begin
            // entry word is on the read port: bump total, stamp, advance time
            ram_wr_en  = 1'b1;
            res_use_in = USE_W'(new_total);
            time_in    = (time_ff == {COUNT_BITS{1'b1}}) ? time_ff : time_ff + 1'b1;
            res_hit_in = cached_ff[idx_addr];
            ptr_in     = '0;
            if (cached_ff[idx_addr] || (capacity_ff == '0)) begin
               state_in = ST_DONE;
            end else begin
               scan_ctl.start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // issue one read per cycle; the scan unit consumes it in the next cycle
            scan_ctl.beat_valid  = pend_valid_ff;
            scan_ctl.beat_cached = pend_cached_ff;
            if (ptr_ff < limit) begin
               pend_valid_in  = 1'b1;
               pend_cached_in = cached_ff[ptr_addr];
               ptr_in         = ptr_ff + 1'b1;
            end else begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (scan_count < capacity_ff) begin
               cached_in[idx_addr] = 1'b1;
               res_ins_in          = 1'b1;
            end else if (scan_found) begin
               cached_in[victim_addr] = 1'b0;
               cached_in[idx_addr]    = 1'b1;
               res_ins_in             = 1'b1;
               res_ev_in              = 1'b1;
               res_victim_in          = scan_victim[IDX_W-1:0];
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_hit_in    = res_hit_ff;
               rsp_ins_in    = res_ins_ff;
               rsp_ev_in     = res_ev_ff;
               rsp_victim_in = res_victim_ff;
               rsp_use_in    = res_use_ff;
               rsp_oor_in    = res_oor_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         capacity_ff   <= CAPACITY_RESET;
         active_ff     <= ACTIVE_RESET;
         time_ff       <= '0;
         cached_ff     <= '0;
         ptr_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         capacity_ff   <= capacity_in;
         active_ff     <= active_in;
         time_ff       <= time_in;
         cached_ff     <= cached_in;
         ptr_ff        <= ptr_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff         <= idx_in;
      pend_cached_ff <= pend_cached_in;
      pend_idx_ff    <= pend_idx_in;
      res_hit_ff     <= res_hit_in;
      res_ins_ff     <= res_ins_in;
      res_ev_ff      <= res_ev_in;
      res_victim_ff  <= res_victim_in;
      res_use_ff     <= res_use_in;
      res_oor_ff     <= res_oor_in;
      rsp_hit_ff     <= rsp_hit_in;
      rsp_ins_ff     <= rsp_ins_in;
      rsp_ev_ff      <= rsp_ev_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_use_ff     <= rsp_use_in;
      rsp_oor_ff     <= rsp_oor_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_was_hit      = rsp_hit_ff;
   assign rsp_inserted     = rsp_ins_ff;
   assign rsp_evicted      = rsp_ev_ff;
   assign rsp_victim_index = rsp_victim_ff;
   assign rsp_use_count    = rsp_use_ff;
   assign rsp_out_of_range = rsp_oor_ff;

endmodule

// ===== hdl/lrue_checker.sv =====
module lrue_checker
   import lrue_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input logic             rsp_was_hit,
   input logic             rsp_inserted,
   input logic             rsp_evicted,
   input logic [IDX_W-1:0] rsp_victim_index,
   input logic [USE_W-1:0] rsp_use_count,
   input logic             rsp_out_of_range
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_use_count)
         && $stable(rsp_victim_index) && $stable(rsp_evicted))
      else $error("result beat changed under stall");

   // a hit never inserts or evicts
   a_hit_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_was_hit |-> !rsp_inserted && !rsp_evicted)
      else $error("hit with insert or evict");

   // eviction always comes with an insert; victim is zero otherwise
   a_evict_ins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_evicted |-> rsp_inserted)
      else $error("evict without insert");

   a_victim_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted |-> rsp_victim_index == '0)
      else $error("victim index set without eviction");

   // out of range beats carry nothing else
   a_oor_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_of_range |-> !rsp_was_hit && !rsp_inserted
         && !rsp_evicted && rsp_use_count == '0)
      else $error("out of range beat with payload");

endmodule

bind lru_entry_cache_policy_core lrue_checker u_lrue_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_was_hit      (rsp_was_hit),
   .rsp_inserted     (rsp_inserted),
   .rsp_evicted      (rsp_evicted),
   .rsp_victim_index (rsp_victim_index),
   .rsp_use_count    (rsp_use_count),
   .rsp_out_of_range (rsp_out_of_range)
);

// ===== tb/lru_entry_cache_policy_checker.sv =====
module lru_entry_cache_policy_checker
   import lrue_pkg::*;
#(
   parameter int ENTRIES = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [IDX_W-1:0]     req_entry_index,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_was_hit,
   input  logic                 rsp_inserted,
   input  logic                 rsp_evicted,
   input  logic [IDX_W-1:0]     rsp_victim_index,
   input  logic [USE_W-1:0]     rsp_use_count,
   input  logic                 rsp_out_of_range,
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output int                   fail_count,
   output int                   backlog
);

   typedef struct packed {
      logic             was_hit;
      logic             inserted;
      logic             evicted;
      logic [IDX_W-1:0] victim_index;
      logic [USE_W-1:0] use_count;
      logic             out_of_range;
   } access_outcome_type;

   access_outcome_type due_outcomes[$];
   access_outcome_type oldest_due;
   logic [USE_W-1:0] use_tally[ENTRIES];
   logic [USE_W-1:0] stamp[ENTRIES];
   logic             cached[ENTRIES];
   logic [USE_W-1:0] now_tick;
   logic [CFG_W-1:0] capacity;
   logic [CFG_W-1:0] active;
   int               mismatches = 0;
   int               waiting = 0;

   assign fail_count = mismatches;
   assign backlog    = waiting;

   // Apply one access to the shadow table and return the beat it should produce.
   function automatic access_outcome_type predict_access(input logic [IDX_W-1:0] idx);
      access_outcome_type o;
      int unsigned     limit;
      int unsigned     occupied;
      int unsigned     oldest;
      bit              found;
      o = '0;
      limit = (active < ENTRIES) ? active : ENTRIES;
      if (idx >= limit) begin
         o.out_of_range = 1'b1;
         return o;
      end
      if (use_tally[idx] != '1) use_tally[idx]++;
      stamp[idx] = now_tick;
      if (now_tick != '1) now_tick++;
      occupied = 0;
      for (int i = 0; i < limit; i++)
         if (cached[i]) occupied++;
      if (cached[idx]) begin
         o.was_hit = 1'b1;
      end else if (capacity != 0) begin
         if (occupied < capacity) begin
            cached[idx] = 1'b1;
            o.inserted = 1'b1;
         end else begin
            // oldest stamp wins, lowest index on ties
            found = 1'b0;
            oldest = 0;
            for (int i = 0; i < limit; i++)
               if (cached[i] && (!found || stamp[i] < stamp[oldest])) begin
                  found = 1'b1;
                  oldest = i;
               end
            if (found) begin
               cached[oldest] = 1'b0;
               cached[idx] = 1'b1;
               o.inserted = 1'b1;
               o.evicted = 1'b1;
               o.victim_index = oldest[IDX_W-1:0];
            end
         end
      end
      o.use_count = use_tally[idx];
      return o;
   endfunction

   function automatic void check_field(input string name, input logic [USE_W-1:0] want,
                                       input logic [USE_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            use_tally[i] = '0;
            stamp[i] = '0;
            cached[i] = 1'b0;
         end
         now_tick = '0;
         capacity = CAPACITY_RESET;
         active = ACTIVE_RESET;
      end else begin
         if (csr_write) begin
            case (csr_index)
               REG_CACHE_CAPACITY: capacity = csr_wdata;
               REG_ACTIVE_ENTRIES: active = csr_wdata;
               default: ;
            endcase
         end
         // a result beat at this edge belongs to an earlier request: check first
         if (rsp_valid && !rsp_stall) begin
            if (due_outcomes.size() == 0) begin
               $error("result beat with no request pending");
               mismatches++;
            end else begin
               oldest_due = due_outcomes.pop_front();
               check_field("was_hit", USE_W'(oldest_due.was_hit), USE_W'(rsp_was_hit));
               check_field("inserted", USE_W'(oldest_due.inserted), USE_W'(rsp_inserted));
               check_field("evicted", USE_W'(oldest_due.evicted), USE_W'(rsp_evicted));
               check_field("victim_index", USE_W'(oldest_due.victim_index),
                           USE_W'(rsp_victim_index));
               check_field("use_count", oldest_due.use_count, rsp_use_count);
               check_field("out_of_range", USE_W'(oldest_due.out_of_range),
                           USE_W'(rsp_out_of_range));
            end
         end
         if (req_valid && !req_stall)
            due_outcomes.push_back(predict_access(req_entry_index));
         waiting = due_outcomes.size();
      end
   end

endmodule

// ===== tb/lru_entry_cache_policy_core_tb.sv =====
module lru_entry_cache_policy_core_tb;
   import lrue_pkg::*;

   localparam int ENTRIES       = 64;
   localparam int RANDOM_ITEMS  = 1450;
   localparam int MAX_GAP       = 16;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [IDX_W-1:0]     req_entry_index;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic                 rsp_was_hit;
   logic                 rsp_inserted;
   logic                 rsp_evicted;
   logic [IDX_W-1:0]     rsp_victim_index;
   logic [USE_W-1:0]     rsp_use_count;
   logic                 rsp_out_of_range;
   logic                 csr_write;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CFG_W-1:0]     csr_wdata;
   int                   fail_count;
   int                   backlog;

   // stimulus bookkeeping
   int  live_limit;        // min(active_entries, ENTRIES) as last written
   int  live_cap;          // cache_capacity as last written
   int  in_range_sent;     // beats that actually touched the table
   bit  send_calm;         // sender runs back to back when set
   bit  take_calm;         // receiver never stalls when set
   int  hold_left;
   int  phase_len;
   int  hot_base;
   int  hot_span;
   logic [CFG_W-1:0] pick_cap;
   logic [CFG_W-1:0] pick_act;
   logic [IDX_W-1:0] pick_idx;

   lru_entry_cache_policy_core #(.ENTRIES(ENTRIES), .COUNT_BITS(USE_W)) dut (.*);

   lru_entry_cache_policy_checker #(.ENTRIES(ENTRIES)) u_checker (.*);

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog: far beyond the slowest legal run (every beat a full 64-entry
   // victim scan, every gap and stall at its maximum).
   initial begin
      #8000000;
      $display("DONE: errors detected");
      $finish;
   end

   // Result side: after each taken beat, draw how long to hold stall high.
   // Now and then switch into a calm stretch with no stalls at all.
   initial hold_left = 0;
   initial take_calm = 1'b0;
   always begin
      @(posedge clock);
      if (rsp_valid && !rsp_stall) begin
         if ($urandom_range(0, 39) == 0) take_calm = !take_calm;
         hold_left = take_calm ? 0 : $urandom_range(0, MAX_GAP);
      end
      @(negedge clock);
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // One register write, one cycle wide; call only while the block is idle.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] which, input logic [CFG_W-1:0] value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= which;
      csr_wdata <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      if (which == REG_ACTIVE_ENTRIES)
         live_limit = (value < ENTRIES) ? value : ENTRIES;
      else
         live_cap = value;
   endtask

   // Present one access beat and return at the falling edge after it is taken.
   // valid stays high into the next beat when no gap is drawn.
   task automatic send_access(input logic [IDX_W-1:0] idx);
      int gap;
      gap = send_calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_entry_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      if (idx < live_limit) in_range_sent++;
   endtask

   // Drop valid and wait until every predicted beat has come back, so the
   // block is surely idle before any register write.
   task automatic quiesce();
      req_valid <= 1'b0;
      while (backlog != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_entry_index = '0;
      rsp_stall = 1'b0;
      csr_write = 1'b0;
      csr_index = REG_CACHE_CAPACITY;
      csr_wdata = '0;
      live_limit = ENTRIES;
      live_cap = CAPACITY_RESET;
      in_range_sent = 0;
      send_calm = 1'b0;
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      // the clearing pass after reset shows up as req_stall; the handshake covers it

      // --- directed part, reset config: capacity 8, all 64 entries live ---
      send_access(6'd0);          // first miss, insert
      send_access(6'd63);         // top index
      send_access(6'd0);          // hit
      for (int i = 1; i <= 6; i++)
         send_access(i[IDX_W-1:0]);   // fill to capacity
      send_access(6'd7);          // full: evicts the oldest stamp (entry 63)
      send_access(6'd63);         // evicts entry 0
      quiesce();

      // no live entries: every index flagged out of range
      write_reg(REG_ACTIVE_ENTRIES, 7'd0);
      send_access(6'd0);
      send_access(6'd63);
      quiesce();

      // active beyond the table (clipped), capacity zero: hits still report,
      // misses insert nothing
      write_reg(REG_ACTIVE_ENTRIES, 7'd127);
      write_reg(REG_CACHE_CAPACITY, 7'd0);
      send_access(6'd5);
      send_access(6'd40);
      quiesce();

      // capacity above the live count: cache never fills
      write_reg(REG_CACHE_CAPACITY, 7'd127);
      write_reg(REG_ACTIVE_ENTRIES, 7'd64);
      send_access(6'd40);
      send_access(6'd41);
      quiesce();

      // shrink the live window: cached entries above it keep their flag but
      // are neither counted nor picked as victims
      write_reg(REG_ACTIVE_ENTRIES, 7'd4);
      write_reg(REG_CACHE_CAPACITY, 7'd2);
      send_access(6'd3);          // hit
      send_access(6'd10);         // out of range
      send_access(6'd0);          // miss with a full window, evicts inside it
      send_access(6'd2);
      quiesce();

      // --- random part: phases of random settings, mostly a hot window so
      // that hits and evictions dominate, the rest spread over all indexes ---
      in_range_sent = 0;
      while (in_range_sent < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: pick_act = 7'd64;
            1: pick_act = 7'd127;
            2: pick_act = 7'd1;
            default: pick_act = CFG_W'($urandom_range(2, ENTRIES));
         endcase
         case ($urandom_range(0, 6))
            0: pick_cap = 7'd0;
            1: pick_cap = 7'd1;
            2: pick_cap = 7'd127;
            3: pick_cap = 7'd64;
            default: pick_cap = CFG_W'($urandom_range(2, 16));
         endcase
         write_reg(REG_ACTIVE_ENTRIES, pick_act);
         write_reg(REG_CACHE_CAPACITY, pick_cap);
         send_calm = ($urandom_range(0, 3) == 0);
         phase_len = $urandom_range(30, 120);
         hot_base = $urandom_range(0, ENTRIES - 1);
         hot_span = ((live_cap < ENTRIES) ? live_cap : ENTRIES) + $urandom_range(0, 4);
         for (int n = 0; n < phase_len; n++) begin
            if ($urandom_range(0, 3) == 0)
               pick_idx = IDX_W'($urandom_range(0, ENTRIES - 1));
            else
               pick_idx = IDX_W'((hot_base + $urandom_range(0, hot_span)) % live_limit);
            send_access(pick_idx);
         end
         quiesce();
      end

      repeat (80) @(negedge clock);
      if (fail_count == 0 && backlog == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lrue_pkg.sv
hdl/lrue_ram.sv
hdl/lrue_scan.sv
hdl/lru_entry_cache_policy_core.sv
hdl/lrue_checker.sv
tb/lru_entry_cache_policy_checker.sv
tb/lru_entry_cache_policy_core_tb.sv
